[src/aecp_pkg.sv]
// ----------------------------------------------------------------------------
// aecp_pkg: shared types and constants for the escape-sequence parser
// Holds the job format passed from the decoder to the command generator,
// the console command codes and the character codes the decoder matches.
// ----------------------------------------------------------------------------
package aecp_pkg;

    localparam logic [7:0] ESC_BYTE      = 8'd27;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_SEMI     = 8'h3B;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_UP       = 8'h41;
    localparam logic [7:0] CHAR_DOWN     = 8'h42;
    localparam logic [7:0] CHAR_RIGHT    = 8'h43;
    localparam logic [7:0] CHAR_LEFT     = 8'h44;
    localparam logic [7:0] CHAR_GOTO     = 8'h66;
    localparam logic [7:0] CHAR_CLEAR    = 8'h4A;
    localparam logic [7:0] CHAR_ERASE_LN = 8'h4B;
    localparam logic [7:0] CHAR_LOWER_P  = 8'h70;
    localparam logic [7:0] CHAR_SAVE     = 8'h73;
    localparam logic [7:0] CHAR_RESTORE  = 8'h75;
    localparam logic [7:0] CHAR_COLOR    = 8'h6D;

    localparam logic       CFG_LAST_ROW   = 1'b0;
    localparam logic       CFG_LAST_COL   = 1'b1;
    localparam logic [7:0] LAST_ROW_RESET = 8'd24;
    localparam logic [7:0] LAST_COL_RESET = 8'd79;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_COLOR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_PUT2,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_GOTO,
        OP_CLEAR,
        OP_COLOR
    } job_op_t;

    // One decoded word. For cursor moves p1 is the step; for color p1 is the
    // background and p2 the foreground.
    typedef struct packed {
        job_op_t    op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] p1;
        logic [7:0] p2;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[src/aecp_front.sv]
// ----------------------------------------------------------------------------
// aecp_front: byte decoder
// Tracks text and escape mode, accumulates the numeric parameters and turns
// each finished sequence or plain byte into at most one job for the queue.
// ----------------------------------------------------------------------------
module aecp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             byte_in,
    input  logic [7:0]             cursor_col,
    input  logic [7:0]             cursor_row,
    input  aecp_pkg::queue_status_t q_status,
    output logic                   push,
    output aecp_pkg::job_t         push_job
);
    import aecp_pkg::*;

    logic       esc_reg, esc_next;
    logic       any_reg, any_next;
    logic       digits_reg, digits_next;
    logic [1:0] sep_reg, sep_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] cur_reg, cur_next;
    logic [7:0] saved_col_reg, saved_col_next;
    logic [7:0] saved_row_reg, saved_row_next;

    logic        in_fire;
    logic        job_valid;
    logic        seq_end;
    logic [7:0]  first_param;
    logic [11:0] accum;

    assign in_ready = !q_status.full;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && job_valid;

    assign first_param = (sep_reg != 2'd0) ? first_reg : cur_reg;
    assign accum = 12'({cur_reg, 3'b000}) + 12'({cur_reg, 1'b0}) + 12'(byte_in[3:0]);

    always_comb
    begin
        esc_next       = esc_reg;
        any_next       = any_reg;
        digits_next    = digits_reg;
        sep_next       = sep_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        job_valid      = 1'b0;
        seq_end        = 1'b0;
        push_job.op    = OP_PUT;
        push_job.ch    = byte_in;
        push_job.col   = cursor_col;
        push_job.row   = cursor_row;
        push_job.p1    = first_param;
        push_job.p2    = 8'd0;

        if (in_fire)
        begin
            if (!esc_reg)
            begin
                if (byte_in == ESC_BYTE)
                begin
                    esc_next    = 1'b1;
                    any_next    = 1'b0;
                    digits_next = 1'b0;
                    sep_next    = 2'd0;
                    first_next  = 8'd0;
                    prev_next   = 8'd0;
                    cur_next    = 8'd0;
                end
                else
                begin
                    job_valid = 1'b1;
                end
            end
            else if (!any_reg)
            begin
                if (byte_in == CHAR_LBRACKET)
                begin
                    any_next = 1'b1;
                end
                else
                begin
                    // ESC not followed by a bracket: both bytes go out as text.
                    esc_next    = 1'b0;
                    job_valid   = 1'b1;
                    push_job.op = OP_PUT2;
                end
            end
            else if (byte_in >= CHAR_ZERO && byte_in <= CHAR_NINE)
            begin
                cur_next    = (accum > 12'd255) ? 8'd255 : accum[7:0];
                digits_next = 1'b1;
            end
            else if (byte_in == CHAR_SEMI)
            begin
                if (sep_reg == 2'd0)
                begin
                    first_next = cur_reg;
                end
                prev_next = cur_reg;
                cur_next  = 8'd0;
                if (sep_reg != 2'd3)
                begin
                    sep_next = sep_reg + 2'd1;
                end
            end
            else
            begin
                case (byte_in)
                    CHAR_UP, CHAR_DOWN:
                    begin
                        seq_end     = 1'b1;
                        job_valid   = 1'b1;
                        push_job.op = (byte_in == CHAR_UP) ? OP_UP : OP_DOWN;
                        push_job.p1 = digits_reg ? first_param : 8'd1;
                    end
                    CHAR_RIGHT, CHAR_LEFT:
                    begin
                        seq_end     = 1'b1;
                        job_valid   = 1'b1;
                        push_job.op = (byte_in == CHAR_RIGHT) ? OP_RIGHT : OP_LEFT;
                    end
                    CHAR_GOTO:
                    begin
                        seq_end      = 1'b1;
                        job_valid    = (sep_reg != 2'd0);
                        push_job.op  = OP_GOTO;
                        push_job.col = cur_reg;
                        push_job.row = first_reg;
                    end
                    CHAR_CLEAR:
                    begin
                        seq_end     = 1'b1;
                        job_valid   = 1'b1;
                        push_job.op = OP_CLEAR;
                    end
                    CHAR_ERASE_LN, CHAR_LOWER_P:
                    begin
                        seq_end = 1'b1;
                    end
                    CHAR_SAVE:
                    begin
                        seq_end        = 1'b1;
                        saved_col_next = cursor_col;
                        saved_row_next = cursor_row;
                    end
                    CHAR_RESTORE:
                    begin
                        seq_end      = 1'b1;
                        job_valid    = 1'b1;
                        push_job.op  = OP_GOTO;
                        push_job.col = saved_col_reg;
                        push_job.row = saved_row_reg;
                    end
                    CHAR_COLOR:
                    begin
                        seq_end     = 1'b1;
                        job_valid   = 1'b1;
                        push_job.op = OP_COLOR;
                        push_job.p1 = (sep_reg != 2'd0) ? cur_reg : 8'd0;
                        push_job.p2 = (sep_reg >= 2'd2) ? prev_reg : 8'd0;
                    end
                    default:
                    begin
                        // Unknown bytes inside a sequence are dropped.
                        seq_end = 1'b0;
                    end
                endcase
                if (seq_end)
                begin
                    esc_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            any_reg       <= 1'b0;
            digits_reg    <= 1'b0;
            sep_reg       <= 2'd0;
            first_reg     <= 8'd0;
            prev_reg      <= 8'd0;
            cur_reg       <= 8'd0;
            saved_col_reg <= 8'd0;
            saved_row_reg <= 8'd0;
        end
        else
        begin
            esc_reg       <= esc_next;
            any_reg       <= any_next;
            digits_reg    <= digits_next;
            sep_reg       <= sep_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
        end
    end

    a_esc_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !esc_reg && byte_in == ESC_BYTE) |=> (esc_reg && !any_reg && sep_reg == 2'd0))
        else $error("ESC in text mode did not start a clean sequence");

endmodule

[src/aecp_queue.sv]
// ----------------------------------------------------------------------------
// aecp_queue: job queue
// Small FIFO between the decoder and the command generator so each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module aecp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  aecp_pkg::job_t          push_job,
    input  logic                    pop,
    output aecp_pkg::job_t          head_job,
    output aecp_pkg::queue_status_t q_status
);
    import aecp_pkg::*;

    job_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_job       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("job queue pushed while full");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH))
            |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("job queue pointers disagree with the fill count");

endmodule

[src/aecp_back.sv]
// ----------------------------------------------------------------------------
// aecp_back: command generator
// Pops jobs, applies the cursor clamps against the configured screen size
// and drives the registered result word, one result per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module aecp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [7:0]              cfg_data,
    input  aecp_pkg::job_t          head_job,
    input  aecp_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              command,
    output logic [7:0]              char_out,
    output logic [7:0]              target_col,
    output logic [7:0]              target_row,
    output logic [7:0]              color_byte,
    output logic                    last_of_run
);
    import aecp_pkg::*;

    logic [7:0] last_row_reg;
    logic [7:0] last_col_reg;
    logic       phase_reg, phase_next;
    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] char_reg, char_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] color_reg, color_next;
    logic       last_reg, last_next;

    logic       load;
    logic       take;
    logic [8:0] row_sum;
    logic [8:0] col_sum;

    assign load    = !valid_reg || out_ready;
    assign take    = load && !q_status.empty;
    assign pop     = take && !(head_job.op == OP_PUT2 && !phase_reg);
    assign row_sum = {1'b0, head_job.row} + {1'b0, head_job.p1};
    assign col_sum = {1'b0, head_job.col} + {1'b0, head_job.p1};

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        char_next  = char_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        color_next = color_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = take;
            cmd_next   = CMD_GOTO;
            char_next  = 8'd0;
            col_next   = head_job.col;
            row_next   = head_job.row;
            color_next = 8'd0;
            last_next  = 1'b1;
            phase_next = 1'b0;
            case (head_job.op)
                OP_PUT:
                begin
                    cmd_next  = CMD_PUT;
                    char_next = head_job.ch;
                    col_next  = 8'd0;
                    row_next  = 8'd0;
                end
                OP_PUT2:
                begin
                    // The ESC goes out first, then the byte that followed it.
                    cmd_next   = CMD_PUT;
                    char_next  = phase_reg ? head_job.ch : ESC_BYTE;
                    col_next   = 8'd0;
                    row_next   = 8'd0;
                    last_next  = phase_reg;
                    phase_next = take && !phase_reg;
                end
                OP_UP:
                begin
                    row_next = (head_job.p1 > head_job.row) ? 8'd0
                                                            : head_job.row - head_job.p1;
                end
                OP_DOWN:
                begin
                    row_next = (row_sum > {1'b0, last_row_reg}) ? last_row_reg
                                                                 : row_sum[7:0];
                end
                OP_RIGHT:
                begin
                    col_next = (col_sum > {1'b0, last_col_reg}) ? last_col_reg
                                                                 : col_sum[7:0];
                end
                OP_LEFT:
                begin
                    col_next = (head_job.p1 > head_job.col) ? 8'd0
                                                            : head_job.col - head_job.p1;
                end
                OP_GOTO:
                begin
                    cmd_next = CMD_GOTO;
                end
                OP_CLEAR:
                begin
                    cmd_next = CMD_CLEAR;
                    col_next = 8'd0;
                    row_next = 8'd0;
                end
                OP_COLOR:
                begin
                    cmd_next   = CMD_COLOR;
                    col_next   = 8'd0;
                    row_next   = 8'd0;
                    color_next = {head_job.p1[3:0], 4'b0000} | head_job.p2;
                end
                default:
                begin
                    cmd_next = CMD_PUT;
                    col_next = 8'd0;
                    row_next = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= LAST_ROW_RESET;
            last_col_reg <= LAST_COL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LAST_ROW)
            begin
                last_row_reg <= cfg_data;
            end
            else
            begin
                last_col_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        char_reg  <= char_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign out_valid   = valid_reg;
    assign command     = cmd_reg;
    assign char_out    = char_reg;
    assign target_col  = col_reg;
    assign target_row  = row_reg;
    assign color_byte  = color_reg;
    assign last_of_run = last_reg;

    a_phase_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!q_status.empty && head_job.op == OP_PUT2 && valid_reg
                       && !last_reg && char_reg == ESC_BYTE))
        else $error("second half of an ESC pair lost its job");

endmodule

[src/ansi_escape_cursor_parser_top.sv]
// ----------------------------------------------------------------------------
// ansi_escape_cursor_parser_top: byte stream to console command decoder
// A result word passes through the job queue, then the result register.
// Throughput: one byte per cycle while the job queue is not full; a lone ESC
// pair leaves the single result register of the command generator as two words.
// A four-entry job queue absorbs output stalls before input is held off.
// Reset (rst_n low, asynchronous) returns to text mode, clears the saved
// cursor and empties the queue; last_row resets to 24, last_column to 79.
// ----------------------------------------------------------------------------
module ansi_escape_cursor_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic [7:0] cursor_col,
    input  logic [7:0] cursor_row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] command,
    output logic [7:0] char_out,
    output logic [7:0] target_col,
    output logic [7:0] target_row,
    output logic [7:0] color_byte,
    output logic       last_of_run
);
    import aecp_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;

    aecp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    aecp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    aecp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_job    (head_job),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .command     (command),
        .char_out    (char_out),
        .target_col  (target_col),
        .target_row  (target_row),
        .color_byte  (color_byte),
        .last_of_run (last_of_run)
    );

endmodule

[tb/aecp_cmd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aecp_cmd_checker: command predictor and scoreboard for the parser
// Watches the byte channel, the command channel and the limit write port.
// Every accepted byte runs through a model of the decoder, and each command
// word it yields waits in a queue until the block delivers its own word.
// ----------------------------------------------------------------------------
module aecp_cmd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic [7:0] cursor_col,
    input  logic [7:0] cursor_row,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] command,
    input  logic [7:0] char_out,
    input  logic [7:0] target_col,
    input  logic [7:0] target_row,
    input  logic [7:0] color_byte,
    input  logic       last_of_run,
    output int         fail_count,
    output int         awaiting,
    output int         cmds_seen
);
    import aecp_pkg::*;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] color;
        logic       last;
    } console_cmd_t;

    console_cmd_t awaited_cmds[$];
    console_cmd_t want;

    logic       in_esc;
    logic       after_bracket;
    logic       have_digits;
    logic [1:0] sep_cnt;
    logic [7:0] first_par;
    logic [7:0] prev_par;
    logic [7:0] cur_par;
    logic [7:0] save_col;
    logic [7:0] save_row;
    logic [7:0] row_lim;
    logic [7:0] col_lim;

    task automatic clear_params();
        after_bracket = 1'b0;
        have_digits   = 1'b0;
        sep_cnt       = 2'd0;
        first_par     = 8'd0;
        prev_par      = 8'd0;
        cur_par       = 8'd0;
    endtask

    task automatic queue_cmd(input cmd_t c, input logic [7:0] ch, input logic [7:0] col,
                             input logic [7:0] row, input logic [7:0] color, input logic last);
        awaited_cmds.push_back('{c, ch, col, row, color, last});
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, exp_val,
                     got_val);
            fail_count++;
        end
    endtask

    // Model of the decoder for one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic [7:0] col,
                               input logic [7:0] row);
        logic [7:0] lead;
        logic [7:0] step;
        logic [7:0] bg;
        logic [7:0] fg;
        int         sum;
        if (!in_esc)
        begin
            if (b == ESC_BYTE)
            begin
                clear_params();
                in_esc = 1'b1;
            end
            else
                queue_cmd(CMD_PUT, b, 8'd0, 8'd0, 8'd0, 1'b1);
        end
        else if (!after_bracket)
        begin
            if (b == CHAR_LBRACKET)
                after_bracket = 1'b1;
            else
            begin
                // Not a control sequence after all: both bytes go out as text.
                in_esc = 1'b0;
                queue_cmd(CMD_PUT, ESC_BYTE, 8'd0, 8'd0, 8'd0, 1'b0);
                queue_cmd(CMD_PUT, b, 8'd0, 8'd0, 8'd0, 1'b1);
            end
        end
        else if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            sum = int'(cur_par) * 10 + int'(b - CHAR_ZERO);
            cur_par = (sum > 255) ? 8'd255 : 8'(sum);
            have_digits = 1'b1;
        end
        else if (b == CHAR_SEMI)
        begin
            if (sep_cnt == 2'd0)
                first_par = cur_par;
            prev_par = cur_par;
            cur_par = 8'd0;
            if (sep_cnt != 2'd3)
                sep_cnt = sep_cnt + 2'd1;
        end
        else
        begin
            lead = (sep_cnt != 2'd0) ? first_par : cur_par;
            step = have_digits ? lead : 8'd1;
            in_esc = 1'b0;
            case (b)
                CHAR_UP:
                    queue_cmd(CMD_GOTO, 8'd0, col, (step > row) ? 8'd0 : row - step, 8'd0,
                              1'b1);
                CHAR_DOWN:
                begin
                    sum = int'(row) + int'(step);
                    queue_cmd(CMD_GOTO, 8'd0, col, (sum > int'(row_lim)) ? row_lim : 8'(sum),
                              8'd0, 1'b1);
                end
                CHAR_RIGHT:
                begin
                    sum = int'(col) + int'(lead);
                    queue_cmd(CMD_GOTO, 8'd0, (sum > int'(col_lim)) ? col_lim : 8'(sum), row,
                              8'd0, 1'b1);
                end
                CHAR_LEFT:
                    queue_cmd(CMD_GOTO, 8'd0, (lead > col) ? 8'd0 : col - lead, row, 8'd0,
                              1'b1);
                CHAR_GOTO:
                begin
                    if (sep_cnt != 2'd0)
                        queue_cmd(CMD_GOTO, 8'd0, cur_par, first_par, 8'd0, 1'b1);
                end
                CHAR_CLEAR:
                    queue_cmd(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
                CHAR_ERASE_LN, CHAR_LOWER_P:
                    ;
                CHAR_SAVE:
                begin
                    save_col = col;
                    save_row = row;
                end
                CHAR_RESTORE:
                    queue_cmd(CMD_GOTO, 8'd0, save_col, save_row, 8'd0, 1'b1);
                CHAR_COLOR:
                begin
                    bg = (sep_cnt != 2'd0) ? cur_par : 8'd0;
                    fg = (sep_cnt >= 2'd2) ? prev_par : 8'd0;
                    queue_cmd(CMD_COLOR, 8'd0, 8'd0, 8'd0, {bg[3:0], 4'd0} | fg, 1'b1);
                end
                default:
                    in_esc = 1'b1;  // Unknown bytes leave the sequence open.
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_esc   = 1'b0;
            clear_params();
            save_col = 8'd0;
            save_row = 8'd0;
            row_lim  = LAST_ROW_RESET;
            col_lim  = LAST_COL_RESET;
            awaited_cmds.delete();
            awaiting = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LAST_ROW)
                    row_lim = cfg_data;
                else
                    col_lim = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                cmds_seen++;
                if (awaited_cmds.size() == 0)
                begin
                    $display("%0t ns: unexpected command word: expected none, got command %0d",
                             $time, command);
                    fail_count++;
                end
                else
                begin
                    want = awaited_cmds.pop_front();
                    check_field("command", want.cmd, command);
                    check_field("char_out", want.ch, char_out);
                    check_field("target_col", want.col, target_col);
                    check_field("target_row", want.row, target_row);
                    check_field("color_byte", want.color, color_byte);
                    check_field("last_of_run", want.last, last_of_run);
                end
            end
            if (in_valid && in_ready)
                decode_byte(byte_in, cursor_col, cursor_row);
            awaiting = awaited_cmds.size();
        end
    end

endmodule

[tb/ansi_escape_cursor_parser_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_escape_cursor_parser_top_tb: stimulus and verdict for the parser
// Feeds plain text, well-formed control sequences with random parameters and
// broken sequences, under several cursor limits, with bursty input and a
// stalling command receiver. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module ansi_escape_cursor_parser_top_tb;
    import aecp_pkg::*;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

    localparam logic [7:0] FINALS [11] = '{CHAR_UP, CHAR_DOWN, CHAR_RIGHT, CHAR_LEFT,
                                           CHAR_GOTO, CHAR_CLEAR, CHAR_SAVE, CHAR_RESTORE,
                                           CHAR_COLOR, CHAR_ERASE_LN, CHAR_LOWER_P};

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic       cfg_index  = CFG_LAST_ROW;
    logic [7:0] cfg_data   = 8'd0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] byte_in    = 8'd0;
    logic [7:0] cursor_col = 8'd0;
    logic [7:0] cursor_row = 8'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [1:0] command;
    logic [7:0] char_out;
    logic [7:0] target_col;
    logic [7:0] target_row;
    logic [7:0] color_byte;
    logic       last_of_run;

    int fail_count;
    int awaiting;
    int cmds_seen;

    int         bytes_sent = 0;
    int         burst_left = 0;
    int         settings_run = 1;
    logic       pin_pos = 1'b0;
    logic [7:0] pos_col = 8'd0;
    logic [7:0] pos_row = 8'd0;
    logic [7:0] row_lim = LAST_ROW_RESET;
    logic [7:0] col_lim = LAST_COL_RESET;

    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_left = 0;
    int       rx_tick = 0;

    ansi_escape_cursor_parser_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .char_out   (char_out),
        .target_col (target_col),
        .target_row (target_row),
        .color_byte (color_byte),
        .last_of_run(last_of_run)
    );

    aecp_cmd_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // The receiver switches at random between stall styles.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_ALWAYS:  out_ready = 1'b1;
            RX_RANDOM:  out_ready = ($urandom_range(0, 9) < 7);
            RX_PATTERN: out_ready = ((rx_tick % 7) >= 3);
            default:    out_ready = ($urandom_range(0, 3) == 0);
        endcase
        rx_tick++;
    end

    function automatic logic [7:0] pick_pos(input logic [7:0] lim);
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return lim;
            3:       return lim + 8'd1;
            4:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drives one word and waits for it to be taken. The sender runs in bursts.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 3)) @(negedge clk);
            else
                repeat ($urandom_range(4, 14)) @(negedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(60, 200);
            else
                burst_left = $urandom_range(1, 24);
        end
        if (!pin_pos)
        begin
            pos_col = pick_pos(col_lim);
            pos_row = pick_pos(row_lim);
        end
        in_valid   = 1'b1;
        byte_in    = b;
        cursor_col = pos_col;
        cursor_row = pos_row;
        burst_left--;
        bytes_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_csi(input string body);
        send_byte(ESC_BYTE);
        send_byte(CHAR_LBRACKET);
        for (int i = 0; i < body.len(); i++)
            send_byte(body[i]);
    endtask

    task automatic send_digits();
        int n;
        case ($urandom_range(0, 19))
            0, 1:                    n = 0;
            2, 3, 4, 5, 6, 7, 8, 9:  n = 1;
            10, 11, 12, 13, 14, 15:  n = 2;
            16, 17:                  n = 3;
            default:                 n = $urandom_range(4, 6);
        endcase
        repeat (n) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // A well-formed sequence with random parameters and an occasional stray byte.
    task automatic send_rand_csi();
        int nparams;
        nparams = $urandom_range(0, 4);
        send_byte(ESC_BYTE);
        send_byte(CHAR_LBRACKET);
        for (int i = 0; i < nparams; i++)
        begin
            if (i > 0)
                send_byte(CHAR_SEMI);
            send_digits();
            if ($urandom_range(0, 19) == 0)
                send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 15) == 0)
            send_byte(8'($urandom_range(8'h40, 8'h7E)));
        send_byte(FINALS[$urandom_range(0, 10)]);
    endtask

    task automatic run_traffic(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4:
                    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
                17:
                begin
                    send_byte(ESC_BYTE);
                    send_byte(8'($urandom_range(0, 255)));
                end
                18:
                begin
                    send_byte(ESC_BYTE);
                    send_byte(CHAR_LBRACKET);
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end
                default:
                    send_rand_csi();
            endcase
        end
    endtask

    // Lets every expected word drain, then idles for sequences that end quietly.
    task automatic drain();
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        logic [7:0] new_row;
        logic [7:0] new_col;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pin_pos = 1'b1;
        pos_col = 8'd0;
        pos_row = 8'd0;
        send_byte(8'h00);
        pos_col = 8'd255;
        pos_row = 8'd255;
        send_byte(8'hFF);
        send_byte(ESC_BYTE);
        send_byte("x");
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        pos_row = 8'd0;
        send_csi("A");
        pos_row = 8'd255;
        send_csi("999B");
        pos_row = 8'd10;
        send_csi("3A");
        pos_col = 8'd255;
        send_csi("C");
        pos_col = 8'd0;
        send_csi("200C");
        pos_col = 8'd3;
        send_csi("7D");
        send_csi("D");
        send_csi("f");
        send_csi("12;34f");
        send_csi("1;2;3;4;300f");
        pos_col = 8'd200;
        pos_row = 8'd100;
        send_csi("s");
        pos_col = 8'd5;
        pos_row = 8'd6;
        send_csi("J");
        send_csi("u");
        send_csi("K");
        send_csi("p");
        send_csi("m");
        send_csi("5m");
        send_csi(";7m");
        send_csi("15;15m");
        send_csi("3;4;255m");
        // Stray bracket, ESC and an unknown letter inside a sequence are skipped.
        send_csi("[4");
        send_byte(ESC_BYTE);
        send_csi(";Z9f");
        pin_pos = 1'b0;

        run_traffic(150);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       begin new_row = 8'd0;   new_col = 8'd0;   end
                1:       begin new_row = 8'd255; new_col = 8'd255; end
                2:       begin new_row = 8'd0;   new_col = 8'd255; end
                3:       begin new_row = 8'd255; new_col = 8'd0;   end
                4:
                begin
                    new_row = 8'($urandom_range(1, 254));
                    new_col = 8'($urandom_range(1, 254));
                end
                default: begin new_row = LAST_ROW_RESET; new_col = LAST_COL_RESET; end
            endcase
            drain();
            write_limit(CFG_LAST_ROW, new_row);
            write_limit(CFG_LAST_COL, new_col);
            row_lim = new_row;
            col_lim = new_col;
            settings_run++;
            run_traffic(160);
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes of text and control sequences under %0d limit settings.",
                 bytes_sent, settings_run);
        $display("Compared %0d command words; %0d mismatches.", cmds_seen, fail_count);
        if (fail_count == 0 && awaiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d command words outstanding.", awaiting);
        $display("status: fail");
        $finish;
    end

endmodule
